@@ sv/dcd_pkg.sv @@
// shared types and constants of the detection candidate decoder
`default_nettype none
package dcd_pkg;

  localparam int SCORE_FIELDS     = 7;
  localparam int CLASS_COUNT_DEF  = 7;

  localparam int COORD_W  = 16;
  localparam int SCORE_W  = 16;
  localparam int CLASS_W  = 3;
  localparam int PAD_W    = 10;
  localparam int INV_W    = 24;
  localparam int FRAME_W  = 13;
  localparam int PIX_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // corner minus pad in 1/32 pixel
  localparam int DIFF_W  = 18;
  // corner times inverse scale in 2^-21 pixel
  localparam int PROD_W  = DIFF_W + INV_W + 1;
  localparam int FRAC_BITS = 21;
  // clamped value, up to 8191 * 2^21
  localparam int CLAMP_W = FRAME_W + FRAC_BITS;

  localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = 16'sd27853;
  localparam logic [PAD_W-1:0]          PAD_RST       = '0;
  localparam logic [INV_W-1:0]          INV_RST       = 24'd65536;
  localparam logic [FRAME_W-1:0]        FRAME_RST     = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCORE_THRESHOLD = 3'd0,
    CFG_PAD_X           = 3'd1,
    CFG_PAD_Y           = 3'd2,
    CFG_INVERSE_SCALE   = 3'd3,
    CFG_FRAME_W         = 3'd4,
    CFG_FRAME_H         = 3'd5
  } cfg_index_t;

  typedef logic [SCORE_FIELDS-1:0][SCORE_W-1:0] score_vec_t;

  // per-word sideband that rides alongside the coordinate math
  typedef struct packed {
    logic                       keep;
    logic [CLASS_W-1:0]         class_id;
    logic signed [SCORE_W-1:0]  best_score;
    logic                       last;
  } meta_t;

  // load enables of the arithmetic stages behind the front stage
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage
`default_nettype wire

@@ sv/dcd_front.sv @@
// first stage: class argmax, keep decision and corner offsets
`default_nettype none
module dcd_front #(
  parameter int CLASS_COUNT = dcd_pkg::CLASS_COUNT_DEF
) (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire logic signed [dcd_pkg::COORD_W-1:0] center_x,
  input  wire logic signed [dcd_pkg::COORD_W-1:0] center_y,
  input  wire logic signed [dcd_pkg::COORD_W-1:0] size_w,
  input  wire logic signed [dcd_pkg::COORD_W-1:0] size_h,
  input  wire dcd_pkg::score_vec_t              scores,
  input  wire                                   last_in,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0] score_threshold,
  input  wire logic [dcd_pkg::PAD_W-1:0]        pad_x,
  input  wire logic [dcd_pkg::PAD_W-1:0]        pad_y,
  output dcd_pkg::meta_t                        meta_r,
  output logic signed [dcd_pkg::DIFF_W-1:0]     dx0_r,
  output logic signed [dcd_pkg::DIFF_W-1:0]     dx1_r,
  output logic signed [dcd_pkg::DIFF_W-1:0]     dy0_r,
  output logic signed [dcd_pkg::DIFF_W-1:0]     dy1_r
);

  localparam int NCLS = (CLASS_COUNT > dcd_pkg::SCORE_FIELDS) ? dcd_pkg::SCORE_FIELDS :
                        (CLASS_COUNT < 1) ? 1 : CLASS_COUNT;

  logic signed [dcd_pkg::SCORE_W-1:0] best;
  logic [dcd_pkg::CLASS_W-1:0]        best_id;
  logic                               keep;
  logic signed [dcd_pkg::DIFF_W-1:0]  cx2, cy2, w_ext, h_ext, padx_s, pady_s;

  // strict greater-than, so the lower index wins a tie
  always_comb begin
    best    = $signed(scores[0]);
    best_id = '0;
    for (int j = 1; j < NCLS; j++) begin
      if ($signed(scores[j]) > best) begin
        best    = $signed(scores[j]);
        best_id = dcd_pkg::CLASS_W'(j);
      end
    end
  end

  assign keep = (best > score_threshold) && (size_w > 0) && (size_h > 0);

  // corners as 2*center -+ size, 1/32 pixel
  assign cx2    = {center_x[dcd_pkg::COORD_W-1], center_x, 1'b0};
  assign cy2    = {center_y[dcd_pkg::COORD_W-1], center_y, 1'b0};
  assign w_ext  = {{2{size_w[dcd_pkg::COORD_W-1]}}, size_w};
  assign h_ext  = {{2{size_h[dcd_pkg::COORD_W-1]}}, size_h};
  assign padx_s = {3'b000, pad_x, 5'b00000};
  assign pady_s = {3'b000, pad_y, 5'b00000};

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r.keep       <= keep;
      meta_r.class_id   <= best_id;
      meta_r.best_score <= best;
      meta_r.last       <= last_in;
      dx0_r <= cx2 - w_ext - padx_s;
      dx1_r <= cx2 + w_ext - padx_s;
      dy0_r <= cy2 - h_ext - pady_s;
      dy1_r <= cy2 + h_ext - pady_s;
    end
  end

endmodule
`default_nettype wire

@@ sv/dcd_axis.sv @@
// one axis: scale, clamp and round the two corners into edge and extent
`default_nettype none
module dcd_axis (
  input  wire                                    clk,
  input  wire dcd_pkg::stage_en_t                en,
  input  wire logic signed [dcd_pkg::DIFF_W-1:0] d_lo,
  input  wire logic signed [dcd_pkg::DIFF_W-1:0] d_hi,
  input  wire logic [dcd_pkg::INV_W-1:0]         inverse_scale,
  input  wire logic [dcd_pkg::FRAME_W-1:0]       limit,
  input  wire                                    keep_s4,
  output logic [dcd_pkg::PIX_W-1:0]              pos_r,
  output logic [dcd_pkg::PIX_W-1:0]              size_r
);

  localparam int CW = dcd_pkg::CLAMP_W;
  localparam int FB = dcd_pkg::FRAC_BITS;
  localparam int PW = dcd_pkg::PROD_W;
  localparam int PIX_W_L = dcd_pkg::PIX_W;

  logic signed [PW-1:0] p_lo_r, p_hi_r;
  logic [CW-1:0]        c_lo_r, c_hi_r;
  logic [CW-1:0]        hi_lim;
  logic [CW-1:0]        c_lo_nxt, c_hi_nxt;
  logic signed [CW:0]   diff_r;
  logic [PIX_W_L-1:0]   pos4_r;
  logic                 keep5_r;
  logic [CW:0]          lo_rnd, diff_rnd;

  assign hi_lim = {limit, {FB{1'b0}}};

  function automatic logic [CW-1:0] clamp(input logic signed [PW-1:0] p,
                                          input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    if (p[PW-1]) begin
      r = '0;
    end else if (p[PW-2:0] > (PW-1)'(hi)) begin
      r = hi;
    end else begin
      r = p[CW-1:0];
    end
    return r;
  endfunction

  assign c_lo_nxt = clamp(p_lo_r, hi_lim);
  assign c_hi_nxt = clamp(p_hi_r, hi_lim);

  // round half up
  assign lo_rnd   = {1'b0, c_lo_r} + ((CW+1)'(1) << (FB-1));
  assign diff_rnd = {1'b0, diff_r[CW-1:0]} + ((CW+1)'(1) << (FB-1));

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_lo_r <= d_lo * $signed({1'b0, inverse_scale});
      p_hi_r <= d_hi * $signed({1'b0, inverse_scale});
    end
    if (en.s3) begin
      c_lo_r <= c_lo_nxt;
      c_hi_r <= c_hi_nxt;
    end
    if (en.s4) begin
      diff_r  <= $signed({1'b0, c_hi_r}) - $signed({1'b0, c_lo_r});
      pos4_r  <= keep_s4 ? lo_rnd[FB+PIX_W_L-1:FB] : '0;
      keep5_r <= keep_s4;
    end
    if (en.s5) begin
      pos_r  <= pos4_r;
      size_r <= (keep5_r && !diff_r[CW]) ? diff_rnd[FB+PIX_W_L-1:FB] : '0;
    end
  end

endmodule
`default_nettype wire

@@ sv/detection_candidate_decode.sv @@
// top level of the detection candidate decoder: config registers, pipeline control, sideband
//
//  channel | ports                          | direction | content
//  --------+--------------------------------+-----------+----------------------------------
//  in      | in_valid / in_ready / in_*     | sink      | one candidate word per transfer
//  out     | out_valid / out_ready / out_*  | source    | one decoded word per candidate
//  cfg     | cfg_valid / cfg_ready / cfg_*  | sink      | register index and write data
//
// five register stages: argmax and corner offsets, multiply by inverse scale,
// clamp to the frame, round edge and take corner difference, round extent
// a word enters every cycle that in_ready is high; an accepted word moves through
// stages 1 to 5 in order, and stage 5 holds out_valid until out_ready takes it
// rst_n (synchronous) clears the stage valid bits and loads register defaults
// each stage holds while its successor is full and stalled, so a stall packs
// the pipeline bubbles out and nothing is lost or repeated
// cfg_ready is always high; registers feed the stages directly
`default_nettype none
module detection_candidate_decode #(
  parameter int CLASS_COUNT = dcd_pkg::CLASS_COUNT_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire logic signed [dcd_pkg::COORD_W-1:0]  in_center_x,
  input  wire logic signed [dcd_pkg::COORD_W-1:0]  in_center_y,
  input  wire logic signed [dcd_pkg::COORD_W-1:0]  in_size_w,
  input  wire logic signed [dcd_pkg::COORD_W-1:0]  in_size_h,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class0,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class1,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class2,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class3,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class4,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class5,
  input  wire logic signed [dcd_pkg::SCORE_W-1:0]  in_score_class6,
  input  wire                                      in_last_in,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic                                     out_keep,
  output logic [dcd_pkg::CLASS_W-1:0]              out_class_id,
  output logic signed [dcd_pkg::SCORE_W-1:0]       out_best_score,
  output logic [dcd_pkg::PIX_W-1:0]                out_box_x,
  output logic [dcd_pkg::PIX_W-1:0]                out_box_y,
  output logic [dcd_pkg::PIX_W-1:0]                out_box_w,
  output logic [dcd_pkg::PIX_W-1:0]                out_box_h,
  output logic                                     out_last_out,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic signed [dcd_pkg::SCORE_W-1:0] thr_r;
  logic [dcd_pkg::PAD_W-1:0]          pad_x_r, pad_y_r;
  logic [dcd_pkg::INV_W-1:0]          inv_r;
  logic [dcd_pkg::FRAME_W-1:0]        frame_w_r, frame_h_r;

  // stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  dcd_pkg::stage_en_t en_ax;

  dcd_pkg::meta_t meta1, meta2_r, meta3_r, meta4_r, meta5_r;
  dcd_pkg::score_vec_t scores;
  logic signed [dcd_pkg::DIFF_W-1:0] dx0, dx1, dy0, dy1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= dcd_pkg::THRESHOLD_RST;
      pad_x_r   <= dcd_pkg::PAD_RST;
      pad_y_r   <= dcd_pkg::PAD_RST;
      inv_r     <= dcd_pkg::INV_RST;
      frame_w_r <= dcd_pkg::FRAME_RST;
      frame_h_r <= dcd_pkg::FRAME_RST;
    end else if (cfg_valid) begin
      unique case (dcd_pkg::cfg_index_t'(cfg_index))
        dcd_pkg::CFG_SCORE_THRESHOLD: thr_r     <= $signed(cfg_data[dcd_pkg::SCORE_W-1:0]);
        dcd_pkg::CFG_PAD_X:           pad_x_r   <= cfg_data[dcd_pkg::PAD_W-1:0];
        dcd_pkg::CFG_PAD_Y:           pad_y_r   <= cfg_data[dcd_pkg::PAD_W-1:0];
        dcd_pkg::CFG_INVERSE_SCALE:   inv_r     <= cfg_data[dcd_pkg::INV_W-1:0];
        dcd_pkg::CFG_FRAME_W:         frame_w_r <= cfg_data[dcd_pkg::FRAME_W-1:0];
        dcd_pkg::CFG_FRAME_H:         frame_h_r <= cfg_data[dcd_pkg::FRAME_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  assign en_ax.s2 = en2;
  assign en_ax.s3 = en3;
  assign en_ax.s4 = en4;
  assign en_ax.s5 = en5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // sideband follows the coordinate stages
  always_ff @(posedge clk) begin
    if (en2) meta2_r <= meta1;
    if (en3) meta3_r <= meta2_r;
    if (en4) meta4_r <= meta3_r;
    if (en5) meta5_r <= meta4_r;
  end

  assign scores[0] = in_score_class0;
  assign scores[1] = in_score_class1;
  assign scores[2] = in_score_class2;
  assign scores[3] = in_score_class3;
  assign scores[4] = in_score_class4;
  assign scores[5] = in_score_class5;
  assign scores[6] = in_score_class6;

  dcd_front #(
    .CLASS_COUNT(CLASS_COUNT)
  ) u_front (
    .clk             (clk),
    .en              (en1),
    .center_x        (in_center_x),
    .center_y        (in_center_y),
    .size_w          (in_size_w),
    .size_h          (in_size_h),
    .scores          (scores),
    .last_in         (in_last_in),
    .score_threshold (thr_r),
    .pad_x           (pad_x_r),
    .pad_y           (pad_y_r),
    .meta_r          (meta1),
    .dx0_r           (dx0),
    .dx1_r           (dx1),
    .dy0_r           (dy0),
    .dy1_r           (dy1)
  );

  // horizontal edge and width; keep comes from the word that stage 4 loads
  dcd_axis u_axis_x (
    .clk           (clk),
    .en            (en_ax),
    .d_lo          (dx0),
    .d_hi          (dx1),
    .inverse_scale (inv_r),
    .limit         (frame_w_r),
    .keep_s4       (meta3_r.keep),
    .pos_r         (out_box_x),
    .size_r        (out_box_w)
  );

  // vertical edge and height
  dcd_axis u_axis_y (
    .clk           (clk),
    .en            (en_ax),
    .d_lo          (dy0),
    .d_hi          (dy1),
    .inverse_scale (inv_r),
    .limit         (frame_h_r),
    .keep_s4       (meta3_r.keep),
    .pos_r         (out_box_y),
    .size_r        (out_box_h)
  );

  assign out_valid      = v5_r;
  assign out_keep       = meta5_r.keep;
  assign out_class_id   = meta5_r.class_id;
  assign out_best_score = meta5_r.best_score;
  assign out_last_out   = meta5_r.last;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// testbench for detection_candidate_decode: random and directed candidates checked by a scoreboard
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dcd_pkg::*;

  // register stages between the in_ and out_ ports
  localparam int LATENCY         = 5;
  localparam int DRAIN_CYCLES    = 2 * LATENCY;
  localparam int HOLD_CYCLES     = 100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int ARGMAX_CLASSES  =
    (CLASS_COUNT_DEF < SCORE_FIELDS) ? CLASS_COUNT_DEF : SCORE_FIELDS;

  // how both sides behave during one phase of the run
  typedef enum {PH_NORMAL, PH_QUIET, PH_PRESSURE} phase_mode_t;

  // one candidate word as it sits on the in_ ports
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] size_w;
    logic signed [COORD_W-1:0] size_h;
    score_vec_t                score;
    logic                      last;
  } candidate_t;

  // one decoded word as it sits on the out_ ports
  typedef struct packed {
    logic                      keep;
    logic [CLASS_W-1:0]        class_id;
    logic signed [SCORE_W-1:0] best_score;
    logic [PIX_W-1:0]          box_x;
    logic [PIX_W-1:0]          box_y;
    logic [PIX_W-1:0]          box_w;
    logic [PIX_W-1:0]          box_h;
    logic                      last;
  } decoded_t;

  // scoreboard: own copy of the registers, box predictor and queue of expected words
  class box_scoreboard;
    logic signed [SCORE_W-1:0] threshold;
    logic [PAD_W-1:0]          pad_x;
    logic [PAD_W-1:0]          pad_y;
    logic [INV_W-1:0]          inv_scale;
    logic [FRAME_W-1:0]        frame_w;
    logic [FRAME_W-1:0]        frame_h;
    decoded_t                  pending_boxes[$];
    int                        errors;

    function new();
      threshold = THRESHOLD_RST;
      pad_x     = PAD_RST;
      pad_y     = PAD_RST;
      inv_scale = INV_RST;
      frame_w   = FRAME_RST;
      frame_h   = FRAME_RST;
      errors    = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCORE_THRESHOLD: threshold = data[SCORE_W-1:0];
        CFG_PAD_X:           pad_x     = data[PAD_W-1:0];
        CFG_PAD_Y:           pad_y     = data[PAD_W-1:0];
        CFG_INVERSE_SCALE:   inv_scale = data[INV_W-1:0];
        CFG_FRAME_W:         frame_w   = data[FRAME_W-1:0];
        CFG_FRAME_H:         frame_h   = data[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    // corner in 1/32 pixel -> pad removed, scaled, clamped, in 2^-21 pixel
    function longint place_corner(longint corner2, logic [PAD_W-1:0] pad,
                                  logic [FRAME_W-1:0] limit);
      longint p;
      longint hi;
      p  = (corner2 - longint'(pad) * 32) * longint'(inv_scale);
      hi = longint'(limit) <<< FRAC_BITS;
      if (p > hi) p = hi;
      if (p < 0) p = 0;
      return p;
    endfunction

    function longint to_pixels(longint v);
      if (v < 0) v = 0;
      return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function decoded_t decode_candidate(candidate_t c);
      decoded_t d;
      logic signed [SCORE_W-1:0] best;
      longint cx2, cy2, w, h, x0, x1, y0, y1;
      best = $signed(c.score[0]);
      d = '0;
      for (int j = 1; j < ARGMAX_CLASSES; j++) begin
        if ($signed(c.score[j]) > best) begin
          best       = $signed(c.score[j]);
          d.class_id = CLASS_W'(j);
        end
      end
      d.best_score = best;
      d.last       = c.last;
      d.keep = (best > threshold) && ($signed(c.size_w) > 0) && ($signed(c.size_h) > 0);
      if (d.keep) begin
        cx2 = 2 * longint'($signed(c.center_x));
        cy2 = 2 * longint'($signed(c.center_y));
        w   = longint'($signed(c.size_w));
        h   = longint'($signed(c.size_h));
        x0  = place_corner(cx2 - w, pad_x, frame_w);
        x1  = place_corner(cx2 + w, pad_x, frame_w);
        y0  = place_corner(cy2 - h, pad_y, frame_h);
        y1  = place_corner(cy2 + h, pad_y, frame_h);
        d.box_x = PIX_W'(to_pixels(x0));
        d.box_y = PIX_W'(to_pixels(y0));
        d.box_w = PIX_W'(to_pixels(x1 - x0));
        d.box_h = PIX_W'(to_pixels(y1 - y0));
      end
      return d;
    endfunction

    function void note_candidate(candidate_t c);
      pending_boxes.insert(pending_boxes.size(), decode_candidate(c));
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        if (errors < 40) $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(decoded_t got);
      decoded_t want;
      if (pending_boxes.size() == 0) begin
        if (errors < 40) $error("result word arrived with nothing expected");
        errors++;
        return;
      end
      want = pending_boxes.pop_front();
      check_field("keep", want.keep, got.keep);
      check_field("class_id", want.class_id, got.class_id);
      check_field("best_score", want.best_score, got.best_score);
      check_field("box_x", want.box_x, got.box_x);
      check_field("box_y", want.box_y, got.box_y);
      check_field("box_w", want.box_w, got.box_w);
      check_field("box_h", want.box_h, got.box_h);
      check_field("last_out", want.last, got.last);
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  candidate_t            in_word = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_index_t            cfg_index = CFG_SCORE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                      in_ready;
  logic                      out_valid;
  logic                      out_keep;
  logic [CLASS_W-1:0]        out_class_id;
  logic signed [SCORE_W-1:0] out_best_score;
  logic [PIX_W-1:0]          out_box_x;
  logic [PIX_W-1:0]          out_box_y;
  logic [PIX_W-1:0]          out_box_w;
  logic [PIX_W-1:0]          out_box_h;
  logic                      out_last_out;
  logic                      cfg_ready;

  // handshake between the stimulus and the receiver process
  bit hold_req = 1'b0;
  bit rx_quiet = 1'b0;

  box_scoreboard sb = new();

  detection_candidate_decode DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_center_x     (in_word.center_x),
    .in_center_y     (in_word.center_y),
    .in_size_w       (in_word.size_w),
    .in_size_h       (in_word.size_h),
    .in_score_class0 (in_word.score[0]),
    .in_score_class1 (in_word.score[1]),
    .in_score_class2 (in_word.score[2]),
    .in_score_class3 (in_word.score[3]),
    .in_score_class4 (in_word.score[4]),
    .in_score_class5 (in_word.score[5]),
    .in_score_class6 (in_word.score[6]),
    .in_last_in      (in_word.last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_keep        (out_keep),
    .out_class_id    (out_class_id),
    .out_best_score  (out_best_score),
    .out_box_x       (out_box_x),
    .out_box_y       (out_box_y),
    .out_box_w       (out_box_w),
    .out_box_h       (out_box_h),
    .out_last_out    (out_last_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // all scores set to fill, one class raised to hot
  function automatic candidate_t make_candidate(int cx, int cy, int w, int h,
                                                int fill, int hot_cls, int hot, bit last);
    candidate_t c;
    c.center_x = COORD_W'(cx);
    c.center_y = COORD_W'(cy);
    c.size_w   = COORD_W'(w);
    c.size_h   = COORD_W'(h);
    for (int j = 0; j < SCORE_FIELDS; j++) c.score[j] = SCORE_W'(fill);
    c.score[hot_cls] = SCORE_W'(hot);
    c.last = last;
    return c;
  endfunction

  // well-formed boxes with one strong class most of the time, raw noise otherwise
  function automatic candidate_t random_candidate();
    candidate_t c;
    int lo, hot, cls, twin;
    if ($urandom_range(0, 9) < 7) begin
      c.center_x = COORD_W'($urandom_range(0, 680 * 16));
      c.center_y = COORD_W'($urandom_range(0, 680 * 16));
      c.size_w   = COORD_W'($urandom_range(1, 700 * 16));
      c.size_h   = COORD_W'($urandom_range(1, 700 * 16));
      for (int j = 0; j < SCORE_FIELDS; j++) c.score[j] = SCORE_W'($urandom);
      // strong class lands at or just around the threshold sometimes
      lo = int'(sb.threshold) - 3;
      if (lo < -32768) lo = -32768;
      hot = $urandom_range(0, 32767 - lo) + lo;
      cls = $urandom_range(0, SCORE_FIELDS - 1);
      c.score[cls] = SCORE_W'(hot);
      // tie on the best score
      if ($urandom_range(0, 7) == 0) begin
        twin = $urandom_range(0, SCORE_FIELDS - 1);
        c.score[twin] = SCORE_W'(hot);
      end
    end else begin
      c.center_x = COORD_W'($urandom);
      c.center_y = COORD_W'($urandom);
      c.size_w   = COORD_W'($urandom);
      c.size_h   = COORD_W'($urandom);
      for (int j = 0; j < SCORE_FIELDS; j++) c.score[j] = SCORE_W'($urandom);
    end
    c.last = ($urandom_range(0, 31) == 0);
    return c;
  endfunction

  // valid stays up across back-to-back words and drops only for a gap
  task automatic send_word(candidate_t c, int gap);
    in_word  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write; cfg_valid is lowered by the caller after the last one
  task automatic drive_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // block must be empty before its registers change
  task automatic wait_idle();
    while (sb.pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_phase_regs(int ph);
    logic [CFG_DATA_W-1:0] thr, px, py, inv, fw, fh;
    thr = $urandom_range(0, 65535);
    px  = $urandom_range(0, 640);
    py  = $urandom_range(0, 640);
    inv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                      : $urandom_range(16384, 4 * 65536);
    fw  = $urandom_range(1, 4096);
    fh  = $urandom_range(1, 4096);
    case (ph)
      // lowest threshold, widest pad and scale, frame beyond 4096
      1: begin
        thr = 24'h008000; px = 1023; py = 1023; inv = 24'hFFFFFF; fw = 8191; fh = 8191;
      end
      // nothing passes the threshold, smallest nonzero scale and frame
      2: begin
        thr = 24'h007FFF; px = 0; py = 0; inv = 1; fw = 1; fh = 1;
      end
      // zero scale and zero frame give zero coordinates
      3: begin
        thr = 0; px = 640; py = 640; inv = 0; fw = 0; fh = 0;
      end
      // usual 1280x720 letterbox into a 640 square
      4: begin
        thr = 8192; px = 0; py = 140; inv = 131072; fw = 1280; fh = 720;
      end
      // unit scale, 4096 frame, negative threshold
      5: begin
        thr = 24'h00FF9C; px = 0; py = 0; inv = 65536; fw = 4096; fh = 4096;
      end
      default: ;
    endcase
    drive_reg(CFG_SCORE_THRESHOLD, thr);
    drive_reg(CFG_PAD_X, px);
    drive_reg(CFG_PAD_Y, py);
    drive_reg(CFG_INVERSE_SCALE, inv);
    drive_reg(CFG_FRAME_W, fw);
    drive_reg(CFG_FRAME_H, fh);
    cfg_valid <= 1'b0;
  endtask

  // edge cases under the reset register values
  task automatic send_directed();
    candidate_t c;
    // all zero: tie over every class, zero size, rejected
    send_word(make_candidate(0, 0, 0, 0, 0, 0, 0, 1'b0), idle_gap());
    // every field at its minimum
    send_word(make_candidate(-32768, -32768, -32768, -32768, -32768, 0, -32768, 1'b1),
              idle_gap());
    // every field at its maximum: tie goes to class 0, box clamped to the frame
    send_word(make_candidate(32767, 32767, 32767, 32767, 32767, 0, 32767, 1'b0),
              idle_gap());
    // each class wins once
    for (int k = 0; k < SCORE_FIELDS; k++)
      send_word(make_candidate(320 * 16, 320 * 16, 100 * 16, 50 * 16, -1000, k, 30000,
                               k == SCORE_FIELDS - 1), idle_gap());
    // score equal to the threshold is rejected, one above is kept
    send_word(make_candidate(200 * 16, 200 * 16, 40 * 16, 40 * 16, 0, 2, 27853, 1'b0),
              idle_gap());
    send_word(make_candidate(200 * 16, 200 * 16, 40 * 16, 40 * 16, 0, 2, 27854, 1'b0),
              idle_gap());
    // zero or negative size rejects a strong candidate
    send_word(make_candidate(1600, 1600, 0, 160, 0, 1, 32000, 1'b0), idle_gap());
    send_word(make_candidate(1600, 1600, 160, 0, 0, 1, 32000, 1'b0), idle_gap());
    send_word(make_candidate(1600, 1600, -16, 160, 0, 1, 32000, 1'b0), idle_gap());
    send_word(make_candidate(1600, 1600, 160, -32768, 0, 1, 32000, 1'b0), idle_gap());
    // tie between classes 3 and 5 goes to 3
    c = make_candidate(1600, 1600, 160, 160, -5, 3, 31000, 1'b0);
    c.score[5] = SCORE_W'(31000);
    send_word(c, idle_gap());
    // center left of the frame, left and top edges clamp to zero
    send_word(make_candidate(-800, -800, 3200, 3200, 0, 4, 30000, 1'b0), idle_gap());
    // a corner or an extent exactly on a half pixel rounds up
    send_word(make_candidate(16, 16, 16, 16, 0, 0, 30000, 1'b0), idle_gap());
    send_word(make_candidate(16, 16, 8, 8, 0, 0, 30000, 1'b0), idle_gap());
    // just under half a pixel rounds down
    send_word(make_candidate(16, 16, 17, 17, 0, 0, 30000, 1'b0), idle_gap());
    // right and bottom edges run past the frame
    send_word(make_candidate(640 * 16, 640 * 16, 32, 32, 0, 6, 30000, 1'b0), idle_gap());
    // alternating bit patterns
    send_word(make_candidate(21845, 21845, 21845, 21845, 21845, 0, 21845, 1'b1),
              idle_gap());
    send_word(make_candidate(-21846, -21846, -21846, -21846, -21846, 0, -21846, 1'b0),
              idle_gap());
  endtask

  task automatic send_random(int count, phase_mode_t mode);
    rx_quiet = (mode == PH_QUIET);
    if (mode == PH_PRESSURE) hold_req = 1'b1;
    for (int n = 0; n < count; n++)
      send_word(random_candidate(), (mode == PH_NORMAL) ? idle_gap() : 0);
    in_valid <= 1'b0;
    rx_quiet = 1'b0;
  endtask

  // receiver: random stalls, a long hold-off on request, none in quiet phases
  initial begin : receiver
    int stall;
    int burst;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = idle_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        burst = $urandom_range(1, 12);
        repeat (burst) @(posedge clk);
      end
    end
  end

  // sample every handshake at the edge where it completes
  always @(posedge clk) begin : port_monitor
    decoded_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_candidate(in_word);
      if (out_valid && out_ready) begin
        got.keep       = out_keep;
        got.class_id   = out_class_id;
        got.best_score = out_best_score;
        got.box_x      = out_box_x;
        got.box_y      = out_box_y;
        got.box_w      = out_box_w;
        got.box_h      = out_box_h;
        got.last       = out_last_out;
        sb.check_word(got);
      end
    end
  end

  // ends the run if no channel moves a word for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready) ||
                    (cfg_valid && cfg_ready)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // phase 0 runs on reset values, later phases reload all registers first
  initial begin : stimulus
    phase_mode_t mode;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    send_random(160, PH_NORMAL);
    wait_idle();
    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      load_phase_regs(ph);
      if (ph == 4) mode = PH_PRESSURE;
      else if (ph == 6) mode = PH_QUIET;
      else mode = PH_NORMAL;
      send_random(ITEMS_PER_PHASE, mode);
      wait_idle();
    end
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending_boxes.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

@@ detection_candidate_decode.f @@
sv/dcd_pkg.sv
sv/dcd_front.sv
sv/dcd_axis.sv
sv/detection_candidate_decode.sv
sim/testbench.sv
